[rtl/assert_macros.svh]
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define SIF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define SIF_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/sif_pkg.sv]
package sif_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_EVEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ODD  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] RST_FLAG      = 8'h7E;
    localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'h7D;
    localparam logic [BYTE_W-1:0] RST_MASK      = 8'h20;
    localparam logic [BYTE_W-1:0] RST_ADDRESS   = 8'h03;
    localparam logic [BYTE_W-1:0] RST_CTRL_EVEN = 8'h00;
    localparam logic [BYTE_W-1:0] RST_CTRL_ODD  = 8'h40;

    typedef struct packed {
        logic [BYTE_W-1:0] flag;
        logic [BYTE_W-1:0] esc;
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] ctrl_even;
        logic [BYTE_W-1:0] ctrl_odd;
    } t_cfg;

    // One classified payload request, as handed from the front to the back.
    typedef struct packed {
        logic [BYTE_W-1:0] payload;
        logic [BYTE_W-1:0] check;
        logic              fstart;
        logic              fend;
        logic              odd;
        logic              pay_stuff;
        logic              chk_stuff;
    } t_desc;

    typedef enum logic [3:0] {
        ST_NEXT,
        ST_FLAG,
        ST_ADDR,
        ST_CTRL,
        ST_HCS,
        ST_PESC,
        ST_PBYTE,
        ST_CESC,
        ST_CBYTE,
        ST_CLOSE
    } t_step;

    function automatic logic needs_stuff(input logic [BYTE_W-1:0] b, input t_cfg cfg);
        needs_stuff = (b == cfg.flag) || (b == cfg.esc);
    endfunction

endpackage

[rtl/stuffed_info_frame_framer_top.sv]
// Channel   Direction  tdata            tlast         tuser
// s (in)    request    payload_byte     frame_end     [0] frame_start, [1] seq_bit
// m (out)   request    line_byte        run_last      [0] closing_flag
// cfg       write      index 0..5, 8-bit data, written on i_cfg_we
//
// Each input request yields one to nine line bytes; the back sequencer sends one
// line byte per cycle while the output is ready and the queue holds a request.
// Input requests are taken whenever the descriptor queue has room (QUEUE_DEPTH
// entries), independently of output stalls, which hold the output register and the sequencer.
// Synchronous active-low reset restores the default configuration, clears the
// running check, empties the queue and drops the output valid.
`include "assert_macros.svh"

module stuffed_info_frame_framer_top #(
    parameter int unsigned QUEUE_DEPTH = sif_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] payload_byte
    input  logic                          i_s_tlast,   // frame_end
    input  logic [1:0]                    i_s_tuser,   // [0] frame_start, [1] seq_bit
    // Output stream.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [7:0]                    o_m_tdata,   // [7:0] line_byte
    output logic                          o_m_tlast,   // run_last
    output logic [0:0]                    o_m_tuser,   // [0] closing_flag
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [sif_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sif_pkg::BYTE_W-1:0]    i_cfg_wdata
);

    sif_pkg::t_cfg  r_cfg;
    sif_pkg::t_desc w_desc;
    sif_pkg::t_desc w_head;
    logic           w_push;
    logic           w_pop;
    logic           w_empty;
    logic           w_full;
    logic           w_close;

    // Configuration registers. Writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag      <= sif_pkg::RST_FLAG;
            r_cfg.esc       <= sif_pkg::RST_ESCAPE;
            r_cfg.mask      <= sif_pkg::RST_MASK;
            r_cfg.addr      <= sif_pkg::RST_ADDRESS;
            r_cfg.ctrl_even <= sif_pkg::RST_CTRL_EVEN;
            r_cfg.ctrl_odd  <= sif_pkg::RST_CTRL_ODD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sif_pkg::CFG_FLAG:      r_cfg.flag      <= i_cfg_wdata;
                sif_pkg::CFG_ESCAPE:    r_cfg.esc       <= i_cfg_wdata;
                sif_pkg::CFG_MASK:      r_cfg.mask      <= i_cfg_wdata;
                sif_pkg::CFG_ADDRESS:   r_cfg.addr      <= i_cfg_wdata;
                sif_pkg::CFG_CTRL_EVEN: r_cfg.ctrl_even <= i_cfg_wdata;
                sif_pkg::CFG_CTRL_ODD:  r_cfg.ctrl_odd  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The front keeps the running check and decides which bytes need stuffing.
    sif_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_payload    (i_s_tdata),
        .i_fstart     (i_s_tuser[0]),
        .i_fend       (i_s_tlast),
        .i_odd        (i_s_tuser[1]),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_desc       (w_desc)
    );

    // Short descriptor queue so that each side stalls on its own.
    sif_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_desc),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // The back walks header, payload, check and closing flag, one byte a cycle unless stalled.
    sif_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_close (w_close)
    );

    assign o_m_tuser[0] = w_close;

    // A closing flag always ends the bytes of its request.
    `SIF_ASSERT_IMPL(a_close_is_last, i_clk, i_rst_n, o_m_tvalid && w_close, o_m_tlast)
    // A closing flag carries the configured delimiter.
    `SIF_ASSERT_IMPL(a_close_is_flag, i_clk, i_rst_n, o_m_tvalid && w_close,
        o_m_tdata == r_cfg.flag)
    // No descriptor is taken off an empty queue.
    `SIF_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_empty)
    // Nothing is presented right after reset.
    `SIF_ASSERT_NEXT(a_reset_idle, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

[rtl/sif_front.sv]
module sif_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sif_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [sif_pkg::BYTE_W-1:0] i_payload,
    input  logic                  i_fstart,
    input  logic                  i_fend,
    input  logic                  i_odd,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output sif_pkg::t_desc        o_desc
);

    logic [sif_pkg::BYTE_W-1:0] r_check;
    logic [sif_pkg::BYTE_W-1:0] n_check;
    logic [sif_pkg::BYTE_W-1:0] w_new_check;

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // Running XOR of the frame's raw bytes; a start restarts it.
    assign w_new_check = (i_fstart ? '0 : r_check) ^ i_payload;

    always_comb begin
        n_check = r_check;
        if (o_push) begin
            n_check = i_fend ? '0 : w_new_check;
        end
    end

    always_comb begin
        o_desc.payload   = i_payload;
        o_desc.check     = w_new_check;
        o_desc.fstart    = i_fstart;
        o_desc.fend      = i_fend;
        o_desc.odd       = i_odd;
        o_desc.pay_stuff = sif_pkg::needs_stuff(i_payload, i_cfg);
        o_desc.chk_stuff = sif_pkg::needs_stuff(w_new_check, i_cfg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check <= '0;
        end else begin
            r_check <= n_check;
        end
    end

endmodule

[rtl/sif_queue.sv]
module sif_queue #(
    parameter int unsigned DEPTH = sif_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sif_pkg::t_desc i_data,
    input  logic           i_pop,
    output sif_pkg::t_desc o_head,
    output logic           o_empty,
    output logic           o_full
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sif_pkg::t_desc r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/sif_back.sv]
module sif_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sif_pkg::t_cfg              i_cfg,
    input  sif_pkg::t_desc             i_head,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [sif_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_last,
    output logic                       o_close
);

    sif_pkg::t_step              r_step;
    sif_pkg::t_step              n_step;
    sif_pkg::t_step              w_cur;
    sif_pkg::t_step              w_after;
    logic                        w_done;
    logic                        w_load;
    logic [sif_pkg::BYTE_W-1:0]  w_ctrl;

    logic                        r_valid;
    logic                        n_valid;
    logic [sif_pkg::BYTE_W-1:0]  r_byte;
    logic [sif_pkg::BYTE_W-1:0]  n_byte;
    logic                        r_last;
    logic                        n_last;
    logic                        r_close;
    logic                        n_close;

    assign w_ctrl  = i_head.odd ? i_cfg.ctrl_odd : i_cfg.ctrl_even;
    assign w_load  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_close = r_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= sif_pkg::ST_NEXT;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_last  <= n_last;
        r_close <= n_close;
    end

    always_comb begin
        // Pick the step to run now; a fresh head starts at its first byte.
        w_cur = r_step;
        if (r_step == sif_pkg::ST_NEXT) begin
            if (i_head.fstart) begin
                w_cur = sif_pkg::ST_FLAG;
            end else if (i_head.pay_stuff) begin
                w_cur = sif_pkg::ST_PESC;
            end else begin
                w_cur = sif_pkg::ST_PBYTE;
            end
        end

        w_after = sif_pkg::ST_NEXT;
        w_done  = 1'b0;
        n_byte  = r_byte;
        n_close = 1'b0;
        case (w_cur)
            sif_pkg::ST_FLAG: begin
                n_byte  = i_cfg.flag;
                w_after = sif_pkg::ST_ADDR;
            end
            sif_pkg::ST_ADDR: begin
                n_byte  = i_cfg.addr;
                w_after = sif_pkg::ST_CTRL;
            end
            sif_pkg::ST_CTRL: begin
                n_byte  = w_ctrl;
                w_after = sif_pkg::ST_HCS;
            end
            sif_pkg::ST_HCS: begin
                n_byte  = i_cfg.addr ^ w_ctrl;
                w_after = i_head.pay_stuff ? sif_pkg::ST_PESC : sif_pkg::ST_PBYTE;
            end
            sif_pkg::ST_PESC: begin
                n_byte  = i_cfg.esc;
                w_after = sif_pkg::ST_PBYTE;
            end
            sif_pkg::ST_PBYTE: begin
                n_byte = i_head.pay_stuff ? (i_head.payload ^ i_cfg.mask) : i_head.payload;
                if (i_head.fend) begin
                    w_after = i_head.chk_stuff ? sif_pkg::ST_CESC : sif_pkg::ST_CBYTE;
                end else begin
                    w_done = 1'b1;
                end
            end
            sif_pkg::ST_CESC: begin
                n_byte  = i_cfg.esc;
                w_after = sif_pkg::ST_CBYTE;
            end
            sif_pkg::ST_CBYTE: begin
                n_byte  = i_head.chk_stuff ? (i_head.check ^ i_cfg.mask) : i_head.check;
                w_after = sif_pkg::ST_CLOSE;
            end
            sif_pkg::ST_CLOSE: begin
                n_byte  = i_cfg.flag;
                n_close = 1'b1;
                w_done  = 1'b1;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase

        n_step  = r_step;
        n_valid = r_valid;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (w_load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_last = w_done;
                if (w_done) begin
                    o_pop  = 1'b1;
                    n_step = sif_pkg::ST_NEXT;
                end else begin
                    n_step = w_after;
                end
            end
        end
        if (!(w_load && !i_empty)) begin
            n_byte  = r_byte;
            n_close = r_close;
        end
    end

endmodule

[verif/stuffed_info_frame_framer_top_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the stuffed information-frame framer.
//
// Requests go in on the slave stream, one payload byte each, with the frame
// start and sequence bit in tuser and the frame end in tlast. Every accepted
// request is run through a local model of the framer. That model produces the
// line bytes the block must send, and they are queued. Each line byte that
// leaves on the master stream is checked against the oldest queued byte.
module stuffed_info_frame_framer_top_test;

    // Indexes past the last register. Writes to them must change nothing.
    localparam logic [sif_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [sif_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int NUM_DIRECTED       = 15;
    localparam int SECOND_SETTING_ROW = 9;   // first directed row under the extreme setting
    localparam int STUCK_LIMIT        = 2000;
    localparam int REPORT_LIMIT       = 30;
    localparam int DRAIN_CYCLES       = 12;  // one full request (nine bytes) plus margin

    // One line byte as it leaves the block.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_last;
        logic       closing_flag;
    } t_line_result;

    // One row of the directed table. When golden_n is nonzero, golden holds the
    // expected line bytes with the first byte in the upper bits.
    typedef struct packed {
        logic [7:0]  payload;
        logic        fstart;
        logic        fend;
        logic        seq;
        logic [3:0]  golden_n;
        logic [71:0] golden;
    } t_frame_row;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_s_tvalid  = 1'b0;
    logic                          o_s_tready;
    logic [7:0]                    i_s_tdata   = '0;   // [7:0] payload_byte
    logic                          i_s_tlast   = 1'b0; // frame_end
    logic [1:0]                    i_s_tuser   = '0;   // [0] frame_start, [1] seq_bit
    logic                          o_m_tvalid;
    logic                          i_m_tready  = 1'b0;
    logic [7:0]                    o_m_tdata;          // [7:0] line_byte
    logic                          o_m_tlast;          // run_last
    logic [0:0]                    o_m_tuser;          // [0] closing_flag
    logic                          i_cfg_we    = 1'b0;
    logic [sif_pkg::CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [sif_pkg::BYTE_W-1:0]    i_cfg_wdata = '0;

    stuffed_info_frame_framer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Model state: the register copy and the running XOR check of the frame.
    sif_pkg::t_cfg cfg_shadow;
    logic [7:0]    frame_check;
    t_line_result  burst_q[$];          // line bytes of the request being modeled
    t_line_result  expected_line_q[$];  // line bytes still owed by the block

    // Expected bytes typed into the table, handed from the driver to the monitor.
    logic [3:0]   req_golden_n = '0;
    logic [71:0]  req_golden   = '0;

    bit steady_run = 1'b0;  // set for the last phase: no idling on either side
    int error_count     = 0;
    int stuck_cycles    = 0;
    int requests_taken  = 0;
    int lines_checked   = 0;
    int frames_closed   = 0;
    int settings_used   = 1;

    // The directed table. The first rows run under the reset setting, where the
    // line bytes can be read straight off the frame format. The rest run under
    // an extreme setting with equal flag and escape values and are left to the
    // model.
    t_frame_row directed_rows [NUM_DIRECTED] = '{
        // Smallest byte, whole frame in one request, even control.
        '{8'h00, 1'b1, 1'b1, 1'b0, 4'd7,
          72'({8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'h00, 8'h7E})},
        // Largest byte, odd control.
        '{8'hFF, 1'b1, 1'b1, 1'b1, 4'd7,
          72'({8'h7E, 8'h03, 8'h40, 8'h43, 8'hFF, 8'hFF, 8'h7E})},
        // A flag byte: both the payload and the check are escaped, nine bytes.
        '{8'h7E, 1'b1, 1'b1, 1'b0, 4'd9,
          {8'h7E, 8'h03, 8'h00, 8'h03, 8'h7D, 8'h5E, 8'h7D, 8'h5E, 8'h7E}},
        // An escape byte opens a longer frame.
        '{8'h7D, 1'b1, 1'b0, 1'b1, 4'd6,
          72'({8'h7E, 8'h03, 8'h40, 8'h43, 8'h7D, 8'h5D})},
        // Closing byte; the check comes out equal to the flag and is escaped.
        '{8'h03, 1'b0, 1'b1, 1'b0, 4'd4,
          72'({8'h03, 8'h7D, 8'h5E, 8'h7E})},
        // Bytes after the close and before any start are sent without a header.
        '{8'h55, 1'b0, 1'b0, 1'b1, 4'd1, 72'(8'h55)},
        '{8'h2A, 1'b0, 1'b0, 1'b0, 4'd1, 72'(8'h2A)},
        // A start inside that stray run clears the check and opens a new header.
        '{8'h01, 1'b1, 1'b0, 1'b0, 4'd5,
          72'({8'h7E, 8'h03, 8'h00, 8'h03, 8'h01})},
        // The check comes out equal to the escape byte.
        '{8'h7C, 1'b0, 1'b1, 1'b0, 4'd4,
          72'({8'h7C, 8'h7D, 8'h5D, 8'h7E})},
        // Extreme setting from here on.
        '{8'h00, 1'b1, 1'b1, 1'b1, 4'd0, '0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 4'd0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b1, 4'd0, '0},
        '{8'hFF, 1'b0, 1'b1, 1'b0, 4'd0, '0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 4'd0, '0},
        '{8'h01, 1'b1, 1'b1, 1'b0, 4'd0, '0}
    };

    function automatic void add_line_byte(input logic [7:0] b, input logic closing);
        t_line_result r;
        r.line_byte    = b;
        r.run_last     = 1'b0;
        r.closing_flag = closing;
        burst_q.push_back(r);
    endfunction

    // A byte equal to the flag or the escape value goes out as escape, byte ^ mask.
    function automatic void add_stuffed_byte(input logic [7:0] b);
        if (b == cfg_shadow.flag || b == cfg_shadow.esc) begin
            add_line_byte(cfg_shadow.esc, 1'b0);
            add_line_byte(b ^ cfg_shadow.mask, 1'b0);
        end else begin
            add_line_byte(b, 1'b0);
        end
    endfunction

    // Fills burst_q with the line bytes one request causes and updates the check.
    function automatic void predict_line_bytes(input logic [7:0] pay, input logic fstart,
                                               input logic fend, input logic odd);
        logic [7:0]   ctrl;
        t_line_result r;
        burst_q.delete();
        ctrl = odd ? cfg_shadow.ctrl_odd : cfg_shadow.ctrl_even;
        if (fstart) begin
            frame_check = '0;
            add_line_byte(cfg_shadow.flag, 1'b0);
            add_line_byte(cfg_shadow.addr, 1'b0);
            add_line_byte(ctrl, 1'b0);
            add_line_byte(cfg_shadow.addr ^ ctrl, 1'b0);
        end
        frame_check = frame_check ^ pay;
        add_stuffed_byte(pay);
        if (fend) begin
            add_stuffed_byte(frame_check);
            add_line_byte(cfg_shadow.flag, 1'b1);
            frame_check = '0;
        end
        r = burst_q.pop_back();
        r.run_last = 1'b1;
        burst_q.push_back(r);
    endfunction

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    // Monitor: checks line bytes, models accepted requests, tracks register
    // writes, and runs the watchdog. Everything is sampled at the rising edge.
    always @(posedge i_clk) begin
        t_line_result want;
        t_line_result r;
        if (!i_rst_n) begin
            cfg_shadow   = '{flag: sif_pkg::RST_FLAG, esc: sif_pkg::RST_ESCAPE,
                             mask: sif_pkg::RST_MASK, addr: sif_pkg::RST_ADDRESS,
                             ctrl_even: sif_pkg::RST_CTRL_EVEN,
                             ctrl_odd: sif_pkg::RST_CTRL_ODD};
            frame_check  = '0;
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;

            // Output side first: a line byte never leaves in the cycle its
            // request is taken, so the queue already holds its expectation.
            if (o_m_tvalid && i_m_tready) begin
                stuck_cycles = 0;
                lines_checked++;
                if (o_m_tuser[0])
                    frames_closed++;
                if (expected_line_q.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected line byte, expected none, actual %h",
                                 $time, o_m_tdata);
                end else begin
                    want = expected_line_q.pop_front();
                    if (o_m_tdata !== want.line_byte)
                        report_field("line_byte", want.line_byte, o_m_tdata);
                    if (o_m_tlast !== want.run_last)
                        report_field("run_last", want.run_last, o_m_tlast);
                    if (o_m_tuser[0] !== want.closing_flag)
                        report_field("closing_flag", want.closing_flag, o_m_tuser[0]);
                end
            end

            if (i_s_tvalid && o_s_tready) begin
                stuck_cycles = 0;
                requests_taken++;
                predict_line_bytes(i_s_tdata, i_s_tuser[0], i_s_tlast, i_s_tuser[1]);
                // A typed row replaces the model's bytes; the model's check still
                // advances so later rows stay in step.
                if (req_golden_n != 0) begin
                    burst_q.delete();
                    for (int k = 0; k < req_golden_n; k++) begin
                        r.line_byte    = req_golden[(req_golden_n - 1 - k) * 8 +: 8];
                        r.run_last     = (k == req_golden_n - 1);
                        r.closing_flag = i_s_tlast && (k == req_golden_n - 1);
                        burst_q.push_back(r);
                    end
                end
                foreach (burst_q[k])
                    expected_line_q.push_back(burst_q[k]);
            end

            if (i_cfg_we) begin
                stuck_cycles = 0;
                case (i_cfg_idx)
                    sif_pkg::CFG_FLAG:      cfg_shadow.flag      = i_cfg_wdata;
                    sif_pkg::CFG_ESCAPE:    cfg_shadow.esc       = i_cfg_wdata;
                    sif_pkg::CFG_MASK:      cfg_shadow.mask      = i_cfg_wdata;
                    sif_pkg::CFG_ADDRESS:   cfg_shadow.addr      = i_cfg_wdata;
                    sif_pkg::CFG_CTRL_EVEN: cfg_shadow.ctrl_even = i_cfg_wdata;
                    sif_pkg::CFG_CTRL_ODD:  cfg_shadow.ctrl_odd  = i_cfg_wdata;
                    default: ;  // spare indexes are ignored by the block
                endcase
            end

            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, STUCK_LIMIT);
                $display("stuffed_info_frame_framer_top test failed");
                $finish;
            end
        end
    end

    // Output stalls: random bursts with tready low.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (!steady_run && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Presents one request and returns at the falling edge after it is taken.
    // Called at a falling edge; tvalid stays high when requests follow back to back.
    task automatic send_request(input logic [7:0] pay, input logic fstart,
                                input logic fend, input logic seq,
                                input logic [3:0] golden_n, input logic [71:0] golden);
        if (!steady_run && $urandom_range(0, 3) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_s_tvalid   = 1'b1;
        i_s_tdata    = pay;
        i_s_tlast    = fend;
        i_s_tuser    = {seq, fstart};
        req_golden_n = golden_n;
        req_golden   = golden;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // Waits until every owed line byte has come out, then lets the block settle.
    task automatic wait_idle();
        i_s_tvalid = 1'b0;
        while (expected_line_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [sif_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
    endtask

    // Loads a full setting while the block is idle, optionally also poking the
    // spare indexes to show they are ignored.
    task automatic apply_setting(input sif_pkg::t_cfg s, input bit poke_spare);
        wait_idle();
        write_reg(sif_pkg::CFG_FLAG, s.flag);
        write_reg(sif_pkg::CFG_ESCAPE, s.esc);
        write_reg(sif_pkg::CFG_MASK, s.mask);
        write_reg(sif_pkg::CFG_ADDRESS, s.addr);
        write_reg(sif_pkg::CFG_CTRL_EVEN, s.ctrl_even);
        write_reg(sif_pkg::CFG_CTRL_ODD, s.ctrl_odd);
        if (poke_spare) begin
            write_reg(CFG_SPARE_LO, 8'hA5);
            write_reg(CFG_SPARE_HI, 8'h5A);
        end
        i_cfg_we = 1'b0;
        settings_used++;
    endtask

    function automatic sif_pkg::t_cfg make_setting(input logic [7:0] flag, esc, mask, addr,
                                                   ctrl_even, ctrl_odd);
        return '{flag: flag, esc: esc, mask: mask, addr: addr,
                 ctrl_even: ctrl_even, ctrl_odd: ctrl_odd};
    endfunction

    // Payload bytes lean toward the values that trigger stuffing.
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 9))
            0, 1:    return cfg_shadow.flag;
            2, 3:    return cfg_shadow.esc;
            4:       return cfg_shadow.flag ^ cfg_shadow.mask;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed frames of random content; the rest are stray bytes
    // outside any frame and requests with random start and end marks.
    task automatic run_random_phase(input int n_items);
        int sent;
        int len;
        logic seq;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                8: begin
                    repeat ($urandom_range(1, 3)) begin
                        send_request(pick_payload(), 1'b0, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 4'd0, '0);
                        sent++;
                    end
                end
                9: begin
                    send_request(pick_payload(), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 4'd0, '0);
                    sent++;
                end
                default: begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                      : $urandom_range(1, 6);
                    seq = 1'($urandom_range(0, 1));
                    for (int k = 0; k < len; k++) begin
                        // The sequence bit only matters on the first byte; later
                        // bytes carry noise there.
                        send_request(pick_payload(), k == 0, k == len - 1,
                                     (k == 0) ? seq : 1'($urandom_range(0, 1)), 4'd0, '0);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        // Reset is held from time zero, then released at a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: reset setting first, then the extreme setting with
        // equal flag and escape values, all-ones mask and address.
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (i == SECOND_SETTING_ROW)
                apply_setting(make_setting(8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00), 1'b1);
            send_request(directed_rows[i].payload, directed_rows[i].fstart,
                         directed_rows[i].fend, directed_rows[i].seq,
                         directed_rows[i].golden_n, directed_rows[i].golden);
        end

        // Random phases, each under its own setting.
        apply_setting(make_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))),
                      1'b0);
        run_random_phase(50);
        apply_setting(make_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0);
        run_random_phase(50);
        apply_setting(make_setting(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        run_random_phase(50);
        begin
            logic [7:0] shared;
            shared = 8'($urandom_range(0, 255));
            apply_setting(make_setting(shared, shared, 8'($urandom_range(1, 255)),
                                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255))), 1'b0);
        end
        run_random_phase(50);

        // Last phase: the reset values written back explicitly, and both sides
        // run flat out so the block is seen at full rate.
        apply_setting(make_setting(sif_pkg::RST_FLAG, sif_pkg::RST_ESCAPE, sif_pkg::RST_MASK,
                                   sif_pkg::RST_ADDRESS, sif_pkg::RST_CTRL_EVEN,
                                   sif_pkg::RST_CTRL_ODD), 1'b0);
        steady_run = 1'b1;
        run_random_phase(50);

        wait_idle();
        $display("Ran %0d requests producing %0d line bytes and %0d closed frames",
                 requests_taken, lines_checked, frames_closed);
        $display("under %0d register settings, with %0d mismatches.",
                 settings_used, error_count);
        if (error_count == 0)
            $display("stuffed_info_frame_framer_top test passed");
        else
            $display("stuffed_info_frame_framer_top test failed");
        $finish;
    end

endmodule
